// File: hw/rtl/tgapd_pkg.sv
// Package for the TGA pixel stream decoder: register indexes, widths and constants.
`timescale 1ns / 1ps
package tgapd_pkg;

	// Field widths
	localparam int BYTE_W  = 8;
	localparam int DIM_W   = 15;
	localparam int PROD_W  = 2 * DIM_W;
	localparam int PHASE_W = 3;
	localparam int ASM_W   = 32;
	localparam int CFG_IDX_W = 2;

	// Packet byte layout
	localparam int RUN_FLAG_BIT = 7;
	localparam logic [BYTE_W-1:0] COUNT_MASK   = 8'h7f;
	localparam logic [BYTE_W-1:0] OPAQUE_ALPHA = 8'hff;

	// Reset values of the registers
	localparam logic [2:0]       PIXEL_BYTES_RST = 3'd4;
	localparam logic             RLE_MODE_RST    = 1'b1;
	localparam logic [DIM_W-1:0] DIM_RST         = 15'd1;

	// Four-byte pixels start at this pixel_bytes value
	localparam logic [2:0] BGRA_BYTES = 3'd4;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PIXEL_BYTES  = 2'd0,
		CFG_RLE_MODE     = 2'd1,
		CFG_IMAGE_WIDTH  = 2'd2,
		CFG_IMAGE_HEIGHT = 2'd3
	} cfg_reg_t;

endpackage

// File: hw/rtl/tga_pixel_stream_decoder.sv
// TGA pixel stream decoder: bytes in, RGBA pixels with repeat counts out.
`timescale 1ns / 1ps
// Takes the pixel-data bytes of a true-color TGA image, one byte per
// transaction, raw (3 or 4 bytes per pixel) or run-length coded, and
// delivers one RGBA result per completed pixel; a run packet yields a single
// result whose repeat_count covers the whole run, clamped to the pixels left
// in the image (overrun flags the clamp, and also a literal packet cut short
// by the end of the image). last_pixel marks the result that completes the
// image, after which the decoder starts over. A byte is accepted every cycle
// while the output side keeps up; each byte passes an input register and one
// level of logic into the result register. The pixel total (width times
// height) is computed by one multiplier when a dimension register is
// written and is held saturated to COUNT_WIDTH bits. The user must write
// registers through the configuration channel only while the decoder is
// idle; the block itself does not enforce this.
module tga_pixel_stream_decoder
	import tgapd_pkg::*;
#(
	parameter int COUNT_WIDTH = 30
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// configuration write channel
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [DIM_W-1:0]     cfg_data,
	// byte input
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [BYTE_W-1:0]    data_byte,
	// pixel output
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [BYTE_W-1:0]    red,
	output logic [BYTE_W-1:0]    green,
	output logic [BYTE_W-1:0]    blue,
	output logic [BYTE_W-1:0]    alpha,
	output logic [BYTE_W-1:0]    repeat_count,
	output logic                 last_pixel,
	output logic                 overrun
);

	localparam int WIDE_W = (COUNT_WIDTH > PROD_W) ? COUNT_WIDTH : PROD_W;
	localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

	// Configuration registers
	logic [2:0]             pixel_bytes_q;
	logic                   rle_mode_q;
	logic [DIM_W-1:0]       width_q;
	logic [DIM_W-1:0]       height_q;
	logic [COUNT_WIDTH-1:0] total_q;

	// Total pixel count from the dimensions, using the value being written
	logic [DIM_W-1:0]       mul_a;
	logic [DIM_W-1:0]       mul_b;
	logic [PROD_W-1:0]      product;
	logic [WIDE_W-1:0]      product_wide;
	logic [WIDE_W-1:0]      max_wide;
	logic [COUNT_WIDTH-1:0] total_d;

	always_comb begin
		mul_a = (cfg_index == CFG_IMAGE_WIDTH) ? cfg_data : width_q;
		mul_b = (cfg_index == CFG_IMAGE_HEIGHT) ? cfg_data : height_q;
		// a zero dimension counts as one
		if (mul_a == '0) begin
			mul_a = DIM_W'(1);
		end
		if (mul_b == '0) begin
			mul_b = DIM_W'(1);
		end
		product      = PROD_W'(mul_a) * PROD_W'(mul_b);
		product_wide = WIDE_W'(product);
		max_wide     = WIDE_W'(COUNT_MAX);
		total_d      = (product_wide > max_wide) ? COUNT_MAX : product_wide[COUNT_WIDTH-1:0];
	end

	assign cfg_ready = 1'b1;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_bytes_q <= PIXEL_BYTES_RST;
			rle_mode_q    <= RLE_MODE_RST;
			width_q       <= DIM_RST;
			height_q      <= DIM_RST;
			total_q       <= COUNT_WIDTH'(1);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_PIXEL_BYTES:  pixel_bytes_q <= cfg_data[2:0];
				CFG_RLE_MODE:     rle_mode_q    <= cfg_data[0];
				CFG_IMAGE_WIDTH:  width_q       <= cfg_data;
				CFG_IMAGE_HEIGHT: height_q      <= cfg_data;
				default:          pixel_bytes_q <= pixel_bytes_q;
			endcase
			total_q <= total_d;
		end
	end

	// Input register and flow control
	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              advance;

	assign advance  = !(out_valid && out_stall);
	assign in_stall = valid_s1 && !advance;

	// stage 1 loads whenever the input is not stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= data_byte;
		end
	end

	// Decoder state
	logic [PHASE_W-1:0]     phase_q;
	logic [ASM_W-1:0]       asm_q;
	logic                   is_run_q;
	logic [BYTE_W-1:0]      lit_left_q;
	logic [COUNT_WIDTH-1:0] done_q;

	// Byte decode
	logic                   work;
	logic                   size4;
	logic                   packet_byte;
	logic [ASM_W-1:0]       asm_new;
	logic [PHASE_W-1:0]     phase_new;
	logic                   emit;
	logic [BYTE_W-1:0]      rep_raw;
	logic [BYTE_W-1:0]      more_owed;
	logic [COUNT_WIDTH-1:0] remaining;
	logic                   clamp;
	logic [BYTE_W-1:0]      rep_out;
	logic                   last;
	logic                   over;

	always_comb begin
		work        = valid_s1 && advance;
		size4       = pixel_bytes_q >= BGRA_BYTES;
		packet_byte = rle_mode_q && (lit_left_q == '0);
		asm_new     = asm_q | (ASM_W'(byte_s1) << {phase_q[1:0], 3'b000});
		phase_new   = phase_q + PHASE_W'(1);
		emit        = work && !packet_byte &&
		              (phase_new >= (size4 ? PHASE_W'(4) : PHASE_W'(3)));
		// repeat and pixels still owed by the packet
		if (rle_mode_q && is_run_q) begin
			rep_raw   = lit_left_q;
			more_owed = '0;
		end else if (rle_mode_q) begin
			rep_raw   = BYTE_W'(1);
			more_owed = lit_left_q - BYTE_W'(1);
		end else begin
			rep_raw   = BYTE_W'(1);
			more_owed = '0;
		end
		// pixels left in the image; a shrunk image has one left
		remaining = (done_q < total_q) ? (total_q - done_q) : COUNT_WIDTH'(1);
		clamp     = COUNT_WIDTH'(rep_raw) > remaining;
		rep_out   = clamp ? remaining[BYTE_W-1:0] : rep_raw;
		last      = clamp || (COUNT_WIDTH'(rep_raw) == remaining);
		over      = clamp || (last && (more_owed != '0));
	end

	// State update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= '0;
			asm_q      <= '0;
			is_run_q   <= 1'b0;
			lit_left_q <= '0;
			done_q     <= '0;
		end else if (work) begin
			if (packet_byte) begin
				is_run_q   <= byte_s1[RUN_FLAG_BIT];
				lit_left_q <= (byte_s1 & COUNT_MASK) + BYTE_W'(1);
				phase_q    <= '0;
			end else if (!emit) begin
				asm_q   <= asm_new;
				phase_q <= phase_new;
			end else if (last) begin
				// image complete: start over
				phase_q    <= '0;
				asm_q      <= '0;
				is_run_q   <= 1'b0;
				lit_left_q <= '0;
				done_q     <= '0;
			end else begin
				done_q  <= done_q + COUNT_WIDTH'(rep_out);
				phase_q <= '0;
				asm_q   <= '0;
				if (rle_mode_q) begin
					lit_left_q <= more_owed;
				end
			end
		end
	end

	// Result register
	logic out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			red          <= asm_new[23:16];
			green        <= asm_new[15:8];
			blue         <= asm_new[7:0];
			alpha        <= size4 ? asm_new[31:24] : OPAQUE_ALPHA;
			repeat_count <= rep_out;
			last_pixel   <= last;
			overrun      <= over;
		end
	end

	assign out_valid = out_valid_q;

	// Checks
	a_repeat_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (repeat_count != '0))
		else $error("result with zero repeat count");

	a_overrun_ends_image: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (!overrun || last_pixel))
		else $error("overrun on a result that does not end the image");

	a_restart_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && last) |=> (done_q == '0 && phase_q == '0 && lit_left_q == '0))
		else $error("state not cleared after the last pixel");

	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q <= PHASE_W'(3))
		else $error("byte phase beyond a four-byte pixel");

endmodule

// File: dv/tb_tga_pixel_stream_decoder.sv
`timescale 1ns / 1ps
// Testbench for the TGA pixel stream decoder: directed and random byte streams checked against a predictor.
module tb_tga_pixel_stream_decoder;
	import tgapd_pkg::*;

	localparam int COUNT_W = 30;
	localparam longint unsigned COUNT_MAX = (64'd1 << COUNT_W) - 1;
	localparam int SETTLE_CYCLES = 8;
	localparam int CYCLE_LIMIT = 400000;
	localparam int RANDOM_ITEMS = 650;

	// One decoded pixel as it leaves the block
	typedef struct packed {
		logic [BYTE_W-1:0] red;
		logic [BYTE_W-1:0] green;
		logic [BYTE_W-1:0] blue;
		logic [BYTE_W-1:0] alpha;
		logic [BYTE_W-1:0] repeat_count;
		logic              last_pixel;
		logic              overrun;
	} pixel_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [DIM_W-1:0]     cfg_data;
	logic                 in_valid;
	logic                 in_stall;
	logic [BYTE_W-1:0]    data_byte;
	logic                 out_valid;
	logic                 out_stall;
	logic [BYTE_W-1:0]    red;
	logic [BYTE_W-1:0]    green;
	logic [BYTE_W-1:0]    blue;
	logic [BYTE_W-1:0]    alpha;
	logic [BYTE_W-1:0]    repeat_count;
	logic                 last_pixel;
	logic                 overrun;

	// Predictor copy of the registers and decoder state
	logic [2:0]         pb_reg;
	logic               rle_reg;
	logic [DIM_W-1:0]   w_reg;
	logic [DIM_W-1:0]   h_reg;
	logic [2:0]         phase;
	logic [ASM_W-1:0]   asm_word;
	logic               run_pkt;
	logic [7:0]         lit_left;
	logic [COUNT_W-1:0] done_cnt;

	pixel_t pending_pixels[$];
	int     mismatch_cnt;
	int     sent_cnt;
	int     cycle_cnt;
	logic   tx_gaps;
	logic   rx_gaps;

	tga_pixel_stream_decoder #(
		.COUNT_WIDTH(COUNT_W)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.data_byte(data_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.red(red),
		.green(green),
		.blue(blue),
		.alpha(alpha),
		.repeat_count(repeat_count),
		.last_pixel(last_pixel),
		.overrun(overrun)
	);

	// Clock
	initial clk = 1'b0;
	always #4 clk = ~clk;

	// Watchdog
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("tb_tga_pixel_stream_decoder: errors");
			$finish;
		end
	end

	function automatic int unsigned pixel_size();
		return (pb_reg <= 3'd3) ? 3 : 4;
	endfunction

	function automatic void clear_image();
		phase = '0;
		asm_word = '0;
		run_pkt = 1'b0;
		lit_left = '0;
		done_cnt = '0;
	endfunction

	// Works out the pixel, if any, that one accepted byte completes
	function automatic void decode_byte(input logic [7:0] b);
		int unsigned     px_size;
		longint unsigned w, h, total, remaining, rep, owed;
		logic            over, last;
		pixel_t          px;
		px_size = pixel_size();
		w = (w_reg == '0) ? 64'd1 : 64'(w_reg);
		h = (h_reg == '0) ? 64'd1 : 64'(h_reg);
		total = w * h;
		if (total > COUNT_MAX)
			total = COUNT_MAX;
		// packet byte opens a new run or literal packet
		if (rle_reg && lit_left == 8'd0) begin
			run_pkt = b[RUN_FLAG_BIT];
			lit_left = (b & COUNT_MASK) + 8'd1;
			phase = '0;
			return;
		end
		asm_word = asm_word | (32'(b) << (8 * phase[1:0]));
		phase = phase + 3'd1;
		if (phase < px_size)
			return;
		if (!rle_reg) begin
			rep = 64'd1;
			owed = 64'd0;
		end else if (run_pkt) begin
			rep = 64'(lit_left);
			owed = 64'd0;
		end else begin
			rep = 64'd1;
			owed = 64'(lit_left) - 64'd1;
		end
		// clamp to what is left of the image
		remaining = (64'(done_cnt) < total) ? total - 64'(done_cnt) : 64'd1;
		over = 1'b0;
		if (rep > remaining) begin
			rep = remaining;
			over = 1'b1;
		end
		last = (rep == remaining);
		if (last && owed != 0)
			over = 1'b1;
		px.red = asm_word[23:16];
		px.green = asm_word[15:8];
		px.blue = asm_word[7:0];
		px.alpha = (px_size == 4) ? asm_word[31:24] : OPAQUE_ALPHA;
		px.repeat_count = rep[7:0];
		px.last_pixel = last;
		px.overrun = over;
		pending_pixels.push_back(px);
		if (last) begin
			clear_image();
		end else begin
			done_cnt = done_cnt + rep[COUNT_W-1:0];
			phase = '0;
			asm_word = '0;
			if (rle_reg)
				lit_left = owed[7:0];
		end
	endfunction

	function automatic void check_field(input string name, input int unsigned exp_val,
			input int unsigned act_val);
		if (exp_val != act_val) begin
			$error("%s: expected %0d, actual %0d", name, exp_val, act_val);
			mismatch_cnt++;
		end
	endfunction

	// Result checker
	always @(posedge clk) begin
		pixel_t exp_px;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_pixels.size() == 0) begin
				$error("pixel transaction with no expected pixel pending");
				mismatch_cnt++;
			end else begin
				exp_px = pending_pixels.pop_front();
				check_field("red", 32'(exp_px.red), 32'(red));
				check_field("green", 32'(exp_px.green), 32'(green));
				check_field("blue", 32'(exp_px.blue), 32'(blue));
				check_field("alpha", 32'(exp_px.alpha), 32'(alpha));
				check_field("repeat_count", 32'(exp_px.repeat_count),
					32'(repeat_count));
				check_field("last_pixel", 32'(exp_px.last_pixel), 32'(last_pixel));
				check_field("overrun", 32'(exp_px.overrun), 32'(overrun));
			end
		end
	end

	// Output side: random stall ahead of each pixel transaction
	initial begin
		int unsigned gap;
		out_stall = 1'b0;
		wait (arst_n);
		forever begin
			gap = rx_gaps ? $urandom_range(7, 0) : 0;
			if (gap != 0) begin
				out_stall <= 1'b1;
				repeat (gap) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!(out_valid && !out_stall));
		end
	end

	task automatic send_byte(input logic [7:0] b);
		int unsigned gap;
		gap = tx_gaps ? $urandom_range(7, 0) : 0;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		do @(posedge clk); while (in_stall);
		decode_byte(b);
		sent_cnt++;
	endtask

	// Sends one pixel in stored B,G,R(,A) order at the current pixel size
	task automatic send_color(input logic [31:0] bgra);
		int unsigned n;
		n = pixel_size();
		for (int i = 0; i < n; i++)
			send_byte(bgra[8*i +: 8]);
	endtask

	// Stops sending and lets every pending pixel arrive
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_pixels.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic cfg_write(input cfg_reg_t idx, input int unsigned val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val[DIM_W-1:0];
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_PIXEL_BYTES:  pb_reg = val[2:0];
			CFG_RLE_MODE:     rle_reg = val[0];
			CFG_IMAGE_WIDTH:  w_reg = val[DIM_W-1:0];
			CFG_IMAGE_HEIGHT: h_reg = val[DIM_W-1:0];
			default:          ;
		endcase
	endtask

	// Writes the registers whose value is not negative; call only when idle
	task automatic configure(input int pb, input int rle, input int w, input int h);
		if (pb >= 0)
			cfg_write(CFG_PIXEL_BYTES, pb);
		if (rle >= 0)
			cfg_write(CFG_RLE_MODE, rle);
		if (w >= 0)
			cfg_write(CFG_IMAGE_WIDTH, w);
		if (h >= 0)
			cfg_write(CFG_IMAGE_HEIGHT, h);
		cfg_valid <= 1'b0;
	endtask

	// Reset values: 4-byte run-length pixels in a 1x1 image
	task automatic test_reset_defaults();
		send_byte(8'h85);
		send_color(32'h8040_2010);
		send_byte(8'h02);
		send_color(32'hff00_ff00);
	endtask

	// Raw pixels, out-of-range pixel sizes 0 and 7 mapping to 3 and 4 bytes
	task automatic test_raw_pixels();
		wait_idle();
		configure(0, 0, 1, 2);
		send_color(32'h0000_0000);
		send_color(32'hffff_ffff);
		wait_idle();
		configure(7, -1, -1, -1);
		send_color(32'hff00_ff00);
		send_color(32'h00ff_00ff);
	endtask

	// Run and literal packets longer than the image, zero width
	task automatic test_rle_packets();
		wait_idle();
		configure(7, 1, 0, 3);
		send_byte(8'hff);
		send_color(32'hffff_ffff);
		send_byte(8'h7f);
		repeat (3) send_color($urandom());
		send_byte(8'h80);
		send_color(32'h0000_0000);
	endtask

	// Image shrunk below the pixels already emitted
	task automatic test_shrunk_image();
		wait_idle();
		configure(4, 1, 10, 10);
		send_byte(8'h84);
		send_color($urandom());
		wait_idle();
		configure(-1, -1, 1, 2);
		send_byte(8'h83);
		send_color($urandom());
	endtask

	// Mode changes in the middle of a literal packet and of a pixel
	task automatic test_mode_switch();
		wait_idle();
		configure(3, 1, 8, 8);
		send_byte(8'h03);
		send_color(32'h0012_3456);
		wait_idle();
		configure(-1, 0, -1, -1);
		send_color($urandom());
		send_color($urandom());
		send_byte(8'ha5);
		wait_idle();
		configure(4, 1, -1, -1);
		send_byte(8'h11);
		send_byte(8'h22);
		send_byte(8'h33);
		send_color($urandom());
		send_color($urandom());
		send_byte(8'h81);
		send_color($urandom());
	endtask

	// Largest dimensions
	task automatic test_huge_image();
		wait_idle();
		configure(4, 1, 32767, 32767);
		repeat (2) begin
			send_byte(8'hff);
			send_color($urandom());
		end
		send_byte(8'h05);
		send_color($urandom());
	endtask

	function automatic int pick_dim();
		int unsigned sel;
		sel = $urandom_range(9, 0);
		if (sel == 0)
			return 0;
		if (sel == 1)
			return 32767;
		if (sel == 2)
			return $urandom_range(32767, 0);
		return $urandom_range(6, 1);
	endfunction

	// Random phases: mostly well-formed packets, some noise and pauses
	task automatic test_random_streams();
		int          stop_at, phase_end;
		int unsigned sel, cnt, npix;
		logic        is_run;
		stop_at = sent_cnt + RANDOM_ITEMS;
		while (sent_cnt < stop_at) begin
			wait_idle();
			tx_gaps = ($urandom_range(3, 0) != 0);
			rx_gaps = ($urandom_range(3, 0) != 0);
			configure(int'($urandom_range(7, 0)), int'($urandom_range(2, 0) != 0),
				pick_dim(), pick_dim());
			phase_end = sent_cnt + int'($urandom_range(100, 40));
			if (phase_end > stop_at)
				phase_end = stop_at;
			while (sent_cnt < phase_end) begin
				sel = $urandom_range(19, 0);
				if (sel == 0) begin
					send_byte(8'($urandom_range(255, 0)));
				end else if (sel == 1) begin
					wait_idle();
				end else if (rle_reg) begin
					cnt = ($urandom_range(3, 0) == 0) ? $urandom_range(127, 0)
						: $urandom_range(3, 0);
					is_run = 1'($urandom_range(1, 0));
					send_byte({is_run, cnt[6:0]});
					npix = is_run ? 1 : ((cnt + 1 > 6) ? 6 : cnt + 1);
					repeat (npix) send_color($urandom());
				end else begin
					send_color($urandom());
				end
			end
		end
	endtask

	// Stimulus sequence
	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		data_byte = '0;
		cfg_valid = 1'b0;
		cfg_index = CFG_PIXEL_BYTES;
		cfg_data = '0;
		tx_gaps = 1'b1;
		rx_gaps = 1'b1;
		mismatch_cnt = 0;
		sent_cnt = 0;
		cycle_cnt = 0;
		pb_reg = PIXEL_BYTES_RST;
		rle_reg = RLE_MODE_RST;
		w_reg = DIM_RST;
		h_reg = DIM_RST;
		clear_image();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_raw_pixels();
		test_rle_packets();
		test_shrunk_image();
		test_mode_switch();
		test_huge_image();
		test_random_streams();
		wait_idle();
		if (pending_pixels.size() != 0) begin
			$error("%0d expected pixels never arrived", pending_pixels.size());
			mismatch_cnt++;
		end
		if (mismatch_cnt == 0) begin
			$display("tb_tga_pixel_stream_decoder: clean");
		end else begin
			$display("tb_tga_pixel_stream_decoder: errors");
		end
		$finish;
	end

endmodule
